/* rtl/ipr_pkg.sv */
// ----------------------------------------------------------------------------
// ipr_pkg
// Shared types and codes of the image plane rotator: register indexes,
// rotation codes, channel widths and the controller to datapath structs.
// ----------------------------------------------------------------------------
package ipr_pkg;

    // channel widths fixed by the item format
    localparam int PIX_IO_W   = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATION     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_HEIGHT = 2'd2;

    // rotation codes, the unused code behaves as a half turn
    localparam logic [1:0] ROT_LEFT  = 2'd0;
    localparam logic [1:0] ROT_RIGHT = 2'd1;
    localparam logic [1:0] ROT_HALF  = 2'd2;

    // input word modes
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_FETCH = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } t_ctrl_state;

    typedef struct packed {
        logic load;     // write accepted pixel to its rotated address
        logic fetch;    // read next pixel of the rotated plane
        logic reject;   // fetch before plane complete
        logic capture;  // store read data into output register
    } t_dp_cmd;

    typedef struct packed {
        logic plane_ready;
        logic out_full;
    } t_dp_status;

endpackage

/* rtl/ipr_in_if.sv */
// ----------------------------------------------------------------------------
// ipr_in_if
// Input channel of the rotator: load or fetch request with pixel bits.
// ----------------------------------------------------------------------------
interface ipr_in_if
    import ipr_pkg::*;
;
    logic                valid;
    logic                ready;
    logic                mode;
    logic [PIX_IO_W-1:0] pixel_in;

    modport source (output valid, output mode, output pixel_in, input ready);
    modport sink (input valid, input mode, input pixel_in, output ready);
endinterface

/* rtl/ipr_out_if.sv */
// ----------------------------------------------------------------------------
// ipr_out_if
// Output channel of the rotator: one rotated pixel per fetch.
// ----------------------------------------------------------------------------
interface ipr_out_if
    import ipr_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [PIX_IO_W-1:0] pixel_out;
    logic                last_of_plane;
    logic                not_loaded;

    modport source (output valid, output pixel_out, output last_of_plane,
                    output not_loaded, input ready);
    modport sink (input valid, input pixel_out, input last_of_plane,
                  input not_loaded, output ready);
endinterface

/* rtl/ipr_cfg_if.sv */
// ----------------------------------------------------------------------------
// ipr_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface ipr_cfg_if
    import ipr_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/ipr_ram.sv */
// ----------------------------------------------------------------------------
// ipr_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ipr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

/* rtl/ipr_ctrl.sv */
// ----------------------------------------------------------------------------
// ipr_ctrl
// Controller of the rotator: accepts words and sequences the store read of
// a fetch into the output register.
// ----------------------------------------------------------------------------
module ipr_ctrl
    import ipr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_mode,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output t_dp_cmd    o_cmd
);
    t_ctrl_state r_state;
    t_ctrl_state n_state;
    logic        accept;

    // output register must be free, or emptied this cycle, before a new word
    assign o_in_ready = (r_state == ST_IDLE) && (!i_status.out_full || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd.load    = accept && (i_in_mode == MODE_LOAD);
        o_cmd.fetch   = accept && (i_in_mode == MODE_FETCH) && i_status.plane_ready;
        o_cmd.reject  = accept && (i_in_mode == MODE_FETCH) && !i_status.plane_ready;
        o_cmd.capture = (r_state == ST_READ);
    end

    always_comb begin
        case (r_state)
            ST_IDLE: begin
                n_state = o_cmd.fetch ? ST_READ : ST_IDLE;
            end
            ST_READ: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

/* rtl/ipr_datapath.sv */
// ----------------------------------------------------------------------------
// ipr_datapath
// Datapath of the rotator: configuration registers, raster counters,
// incremental rotated address, plane store and output register.
// ----------------------------------------------------------------------------
module ipr_datapath
    import ipr_pkg::*;
#(
    parameter int MAX_DIM    = 256,
    parameter int PIXEL_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [PIX_IO_W-1:0]   i_pixel_in,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [PIX_IO_W-1:0]   o_pixel_out,
    output logic                  o_last_of_plane,
    output logic                  o_not_loaded
);
    localparam int DEPTH     = MAX_DIM * MAX_DIM;
    localparam int IW        = $clog2(MAX_DIM);
    localparam int DIM_W     = $clog2(MAX_DIM + 1);
    localparam int LW        = DIM_W + 1;
    localparam int CW        = (DIM_W > CFG_DATA_W) ? DIM_W : CFG_DATA_W;
    localparam int AW        = $clog2(DEPTH);
    localparam int TW        = $clog2(DEPTH + 1);
    localparam int DIM_RESET = (MAX_DIM < 256) ? MAX_DIM : 256;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v);
        logic [CW-1:0]    ve;
        logic [DIM_W-1:0] r;
        ve = CW'(v);
        if (ve == '0) begin
            r = DIM_W'(1);
        end else if (ve > CW'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM);
        end else begin
            r = DIM_W'(ve);
        end
        return r;
    endfunction

    logic [1:0]       r_rot, n_rot;
    logic [DIM_W-1:0] r_w, n_w;
    logic [DIM_W-1:0] r_h, n_h;
    logic [TW-1:0]    r_total, n_total;
    logic [IW-1:0]    r_col, n_col;
    logic [IW-1:0]    r_row, n_row;
    logic [AW-1:0]    r_addr, n_addr;
    logic [AW-1:0]    r_row_base, n_row_base;
    logic [AW-1:0]    r_fetch_idx, n_fetch_idx;
    logic             r_plane_ready, n_plane_ready;
    logic             r_fetch_last, n_fetch_last;
    logic             r_out_valid, n_out_valid;
    logic [PIX_IO_W-1:0] r_pixel, n_pixel;
    logic             r_last, n_last;
    logic             r_nl, n_nl;

    logic                  cfg_hit;
    logic [DIM_W-1:0]      cfg_w;
    logic [DIM_W-1:0]      cfg_h;
    logic                  col_wrap;
    logic                  row_wrap;
    logic [AW-1:0]         h_a;
    logic [AW-1:0]         start_addr;
    logic [AW-1:0]         row_addr;
    logic [AW-1:0]         step_addr;
    logic [AW-1:0]         wr_addr;
    logic                  fetch_last;
    logic [PIXEL_BITS-1:0] ram_rdata;

    assign cfg_hit = i_cfg_valid && ((i_cfg_index == CFG_ROTATION)
                     || (i_cfg_index == CFG_PLANE_WIDTH)
                     || (i_cfg_index == CFG_PLANE_HEIGHT));
    assign cfg_w = (i_cfg_index == CFG_PLANE_WIDTH) ? clamp_dim(i_cfg_data) : r_w;
    assign cfg_h = (i_cfg_index == CFG_PLANE_HEIGHT) ? clamp_dim(i_cfg_data) : r_h;

    assign col_wrap   = (LW'(r_col) + LW'(1)) >= LW'(r_w);
    assign row_wrap   = (LW'(r_row) + LW'(1)) >= LW'(r_h);
    assign h_a        = AW'(r_h);
    assign fetch_last = (TW'(r_fetch_idx) + TW'(1)) == r_total;

    // rotated address walks by a constant step along a row and by one per row
    always_comb begin
        case (r_rot)
            ROT_LEFT: begin
                start_addr = AW'(r_total - TW'(r_h));
                row_addr   = r_row_base + AW'(1);
                step_addr  = r_addr - h_a;
            end
            ROT_RIGHT: begin
                start_addr = AW'(r_h - DIM_W'(1));
                row_addr   = r_row_base - AW'(1);
                step_addr  = r_addr + h_a;
            end
            default: begin
                // half turn: plain reverse of the raster order
                start_addr = AW'(r_total - TW'(1));
                row_addr   = r_addr - AW'(1);
                step_addr  = r_addr - AW'(1);
            end
        endcase
        if (r_col == '0 && r_row == '0) begin
            wr_addr = start_addr;
        end else if (r_col == '0) begin
            wr_addr = row_addr;
        end else begin
            wr_addr = step_addr;
        end
    end

    always_comb begin
        n_rot         = r_rot;
        n_w           = r_w;
        n_h           = r_h;
        n_total       = r_total;
        n_col         = r_col;
        n_row         = r_row;
        n_addr        = r_addr;
        n_row_base    = r_row_base;
        n_fetch_idx   = r_fetch_idx;
        n_plane_ready = r_plane_ready;
        n_fetch_last  = r_fetch_last;

        if (cfg_hit) begin
            if (i_cfg_index == CFG_ROTATION) begin
                n_rot = i_cfg_data[1:0];
            end
            n_w           = cfg_w;
            n_h           = cfg_h;
            n_total       = TW'(cfg_w * cfg_h);
            n_col         = '0;
            n_row         = '0;
            n_fetch_idx   = '0;
            n_plane_ready = 1'b0;
        end else if (i_cmd.load) begin
            n_addr        = wr_addr;
            n_fetch_idx   = '0;
            n_plane_ready = 1'b0;
            if (r_col == '0) begin
                n_row_base = wr_addr;
            end
            if (col_wrap) begin
                n_col = '0;
                if (row_wrap) begin
                    n_row         = '0;
                    n_plane_ready = 1'b1;
                end else begin
                    n_row = r_row + IW'(1);
                end
            end else begin
                n_col = r_col + IW'(1);
            end
        end else if (i_cmd.fetch) begin
            n_fetch_last = fetch_last;
            if (fetch_last) begin
                n_fetch_idx   = '0;
                n_plane_ready = 1'b0;
            end else begin
                n_fetch_idx = r_fetch_idx + AW'(1);
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_pixel     = r_pixel;
        n_last      = r_last;
        n_nl        = r_nl;
        if (i_cmd.capture) begin
            n_out_valid = 1'b1;
            n_pixel     = PIX_IO_W'(ram_rdata);
            n_last      = r_fetch_last;
            n_nl        = 1'b0;
        end else if (i_cmd.reject) begin
            n_out_valid = 1'b1;
            n_pixel     = '0;
            n_last      = 1'b0;
            n_nl        = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot         <= ROT_LEFT;
            r_w           <= DIM_W'(DIM_RESET);
            r_h           <= DIM_W'(DIM_RESET);
            r_total       <= TW'(DIM_RESET * DIM_RESET);
            r_col         <= '0;
            r_row         <= '0;
            r_fetch_idx   <= '0;
            r_plane_ready <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_rot         <= n_rot;
            r_w           <= n_w;
            r_h           <= n_h;
            r_total       <= n_total;
            r_col         <= n_col;
            r_row         <= n_row;
            r_fetch_idx   <= n_fetch_idx;
            r_plane_ready <= n_plane_ready;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr       <= n_addr;
        r_row_base   <= n_row_base;
        r_fetch_last <= n_fetch_last;
        r_pixel      <= n_pixel;
        r_last       <= n_last;
        r_nl         <= n_nl;
    end

    ipr_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load),
        .i_waddr (wr_addr),
        .i_wdata (i_pixel_in[PIXEL_BITS-1:0]),
        .i_re    (i_cmd.fetch),
        .i_raddr (r_fetch_idx),
        .o_rdata (ram_rdata)
    );

    assign o_status.plane_ready = r_plane_ready;
    assign o_status.out_full    = r_out_valid;
    assign o_out_valid          = r_out_valid;
    assign o_pixel_out          = r_pixel;
    assign o_last_of_plane      = r_last;
    assign o_not_loaded         = r_nl;
endmodule

/* rtl/image_plane_rotator_core.sv */
// ----------------------------------------------------------------------------
// image_plane_rotator_core
// Rotates an image plane by 90 degrees left, 90 degrees right or 180 degrees
// through a plane store of MAX_DIM x MAX_DIM pixels.
// ----------------------------------------------------------------------------
// Load words carry the pixels of a plane in raster order and each is written
// straight to its rotated address, one load per clock. Once the plane is
// complete, fetch words read it out in rotated raster order, one result word
// per fetch, the final one flagged last_of_plane; each fetch passes through
// the registered read of the plane store and then into the output register.
// A fetch before the plane is complete returns zero with not_loaded set.
// Loads produce no result. A new word is taken only while the output
// register is empty or being emptied. The store is not cleared after reset.
// Any write to the rotation, width or height register restarts the plane.
// ----------------------------------------------------------------------------
module image_plane_rotator_core
    import ipr_pkg::*;
#(
    parameter int MAX_DIM    = 256,
    parameter int PIXEL_BITS = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    ipr_in_if.sink   i_pix,
    ipr_cfg_if.sink  i_cfg,
    ipr_out_if.source o_res
);
    t_dp_cmd    cmd;
    t_dp_status status;

    assign i_cfg.ready = 1'b1;

    ipr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pix.valid),
        .i_in_mode   (i_pix.mode),
        .i_out_ready (o_res.ready),
        .i_status    (status),
        .o_in_ready  (i_pix.ready),
        .o_cmd       (cmd)
    );

    ipr_datapath #(
        .MAX_DIM    (MAX_DIM),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_cfg_valid     (i_cfg.valid),
        .i_cfg_index     (i_cfg.index),
        .i_cfg_data      (i_cfg.data),
        .i_pixel_in      (i_pix.pixel_in),
        .i_out_ready     (o_res.ready),
        .o_out_valid     (o_res.valid),
        .o_pixel_out     (o_res.pixel_out),
        .o_last_of_plane (o_res.last_of_plane),
        .o_not_loaded    (o_res.not_loaded)
    );
endmodule
